>>> rtl/swdv_pkg.sv
package swdv_pkg;

	localparam int VAL_W = 32;
	localparam int CAP_W = 5;
	localparam int CNT_OUT_W = 5;
	localparam int STATUS_W = 2;
	localparam int FULL_W = 2;
	localparam int M_DATA_W = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [FULL_W-1:0] {
		FL_ROOM  = 2'd0,
		FL_FULL  = 2'd1,
		FL_EMPTY = 2'd2
	} fullness_t;

	// Per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic             push;
		logic             remove;
		logic [VAL_W-1:0] value;
	} swdv_ctl_t;

endpackage

>>> rtl/swdv_cell.sv
module swdv_cell #(
	parameter int IDX = 0,
	parameter int CW = 5
) (
	input  logic                    clk,
	input  swdv_pkg::swdv_ctl_t     ctl,
	input  logic [CW-1:0]           count,
	input  logic [swdv_pkg::VAL_W-1:0] above_data,
	input  logic                    hit_in,
	output logic                    hit_out,
	output logic [swdv_pkg::VAL_W-1:0] data
);
	import swdv_pkg::*;

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic [VAL_W-1:0] entry_q;
	logic             live;
	logic             match;
	logic             push_here;
	logic             shift;

	assign live      = IDX_C < count;
	assign match     = live && (entry_q == ctl.value);
	assign hit_out   = hit_in | match;
	assign push_here = ctl.push && (count == IDX_C);
	// advance from the neighbor above when no hit lies above this cell
	assign shift     = ctl.remove && !hit_in;
	assign data      = entry_q;

	always_ff @(posedge clk) begin
		if (push_here) begin
			entry_q <= ctl.value;
		end else if (shift) begin
			entry_q <= above_data;
		end
	end

endmodule

>>> rtl/stack_with_delete_by_value_core.sv
// Bounded LIFO stack of signed 32-bit words with delete by value.
// Input stream (s_axis_*): tuser selects the operation (0 push, 1 remove),
// tdata carries the value to push or to search for.
// Output stream (m_axis_*): one transaction per input transaction, carrying
// the status, the fullness after the step and the entry count after the step.
// Configuration: cfg_we writes cfg_wdata into the capacity register; a zero
// capacity acts as 1, a capacity above DEPTH acts as DEPTH.
// The entries live in a chain of DEPTH cells. Each cell compares its word
// with the search value and a hit flag ripples down from the top, so the
// topmost match is found in the same cycle; cells at and above it take the
// word of their upper neighbor to close the gap.
// The result is registered and appears in the cycle after the input transaction.
// Throughput: one transaction per cycle while the output is taken; the
// single output register stalls the input when it holds a result that is
// not taken, and the result then holds until m_axis_tready is high.
// Reset: the stack is empty and capacity is 16; no clearing pass is needed.
module stack_with_delete_by_value_core #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [swdv_pkg::CAP_W-1:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [swdv_pkg::VAL_W-1:0] s_axis_tdata,  // value[31:0]
	input  logic        s_axis_tuser,                 // operation[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[1:0], fullness[3:2], entry_count[8:4], zero[15:9]
	output logic [swdv_pkg::M_DATA_W-1:0] m_axis_tdata
);
	import swdv_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = (CW > CAP_W) ? CW : CAP_W;
	localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);
	localparam logic [EW-1:0] ONE_E = EW'(1);

	logic [CAP_W-1:0]  cap_q;
	logic [CW-1:0]     count_q;
	logic              out_valid_q;
	status_t           out_status_q;
	fullness_t         out_fullness_q;
	logic [CW-1:0]     out_count_q;

	logic              s_fire;
	logic              found;
	logic [EW-1:0]     cap_e;
	logic [EW-1:0]     eff_cap;
	logic [EW-1:0]     count_e;
	logic [EW-1:0]     next_e;
	logic              at_cap;
	status_t           status_d;
	fullness_t         fullness_d;
	logic [CW-1:0]     count_d;
	swdv_ctl_t         ctl;

	logic [DEPTH:0]    hit;
	logic [VAL_W-1:0]  cell_data [DEPTH];

	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !out_valid_q || m_axis_tready;

	assign cap_e   = EW'(cap_q);
	assign count_e = EW'(count_q);

	always_comb begin
		eff_cap = (cap_e == '0) ? ONE_E : cap_e;
		if (eff_cap > DEPTH_E) begin
			eff_cap = DEPTH_E;
		end
	end

	assign at_cap = count_e >= eff_cap;
	assign found  = hit[0];

	always_comb begin
		status_d = ST_DONE;
		count_d  = count_q;
		if (s_axis_tuser == OP_PUSH) begin
			if (at_cap) begin
				status_d = ST_FULL;
			end else begin
				count_d = count_q + CW'(1);
			end
		end else begin
			if (count_q == '0) begin
				status_d = ST_EMPTY;
			end else if (!found) begin
				status_d = ST_NOT_FOUND;
			end else begin
				count_d = count_q - CW'(1);
			end
		end
	end

	always_comb begin
		next_e = EW'(count_d);
		if (count_d == '0) begin
			fullness_d = FL_EMPTY;
		end else if (next_e >= eff_cap) begin
			fullness_d = FL_FULL;
		end else begin
			fullness_d = FL_ROOM;
		end
	end

	assign ctl.push   = s_fire && (s_axis_tuser == OP_PUSH) && !at_cap;
	assign ctl.remove = s_fire && (s_axis_tuser == OP_REMOVE) && found;
	assign ctl.value  = s_axis_tdata;

	assign hit[DEPTH] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] above;
		if (i == DEPTH - 1) begin : g_top
			assign above = cell_data[i];
		end else begin : g_mid
			assign above = cell_data[i+1];
		end
		swdv_cell #(
			.IDX(i),
			.CW (CW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.count     (count_q),
			.above_data(above),
			.hit_in    (hit[i+1]),
			.hit_out   (hit[i]),
			.data      (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_fire) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			out_status_q   <= status_d;
			out_fullness_q <= fullness_d;
			out_count_q    <= count_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(M_DATA_W - STATUS_W - FULL_W - CNT_OUT_W){1'b0}},
		CNT_OUT_W'(out_count_q) & {CNT_OUT_W{1'b1}},
		out_fullness_q, out_status_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && s_axis_tuser == OP_PUSH && status_d == ST_DONE)
		|=> count_q == $past(count_q) + CW'(1))
		else $error("accepted push did not grow the stack");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && s_axis_tuser == OP_REMOVE && status_d == ST_DONE)
		|=> count_q == $past(count_q) - CW'(1))
		else $error("accepted remove did not shrink the stack");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_FULL) |-> out_fullness_q == FL_FULL)
		else $error("dropped push not reported full");

	a_empty_remove: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_EMPTY) |-> out_fullness_q == FL_EMPTY)
		else $error("remove on empty not reported empty");

endmodule
